/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared constants, types and round functions of the SHA-256 block hash.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  localparam int HASH_WORDS  = 8;
  localparam int ROUNDS      = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int WIDX_W  = $clog2(BLOCK_WORDS);
  localparam int HIDX_W  = $clog2(HASH_WORDS);
  localparam int RND_W   = $clog2(ROUNDS);
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HASH_WORDS-1:0][WORD_W-1:0] hash_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] block_words_t;

  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef struct packed {
    block_words_t words;
    logic         reload;
    logic         fin;
  } sha_block_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } sha_state_t;

  function automatic word_t big_s0(input word_t x);
    return ((x >> 2) | (x << 30)) ^ ((x >> 13) | (x << 19)) ^ ((x >> 22) | (x << 10));
  endfunction

  function automatic word_t big_s1(input word_t x);
    return ((x >> 6) | (x << 26)) ^ ((x >> 11) | (x << 21)) ^ ((x >> 25) | (x << 7));
  endfunction

  function automatic word_t small_s0(input word_t x);
    return ((x >> 7) | (x << 25)) ^ ((x >> 18) | (x << 14)) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(input word_t x);
    return ((x >> 17) | (x << 15)) ^ ((x >> 19) | (x << 13)) ^ (x >> 10);
  endfunction

  function automatic word_t round_k(input logic [RND_W-1:0] t);
    word_t k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

/* rtl/sha_in_if.sv */
// ----------------------------------------------------------------------------
// SHA-256 message word channel
// Valid/ready channel that carries one message word and its block flags.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic        new_message;
  logic        final_block;

  modport source (output valid, output msg_word, output new_message, output final_block,
                  input ready);
  modport sink (input valid, input msg_word, input new_message, input final_block,
                output ready);
endinterface

/* rtl/sha_out_if.sv */
// ----------------------------------------------------------------------------
// SHA-256 digest word channel
// Valid/ready channel that carries one digest word and its end marker.
// ----------------------------------------------------------------------------
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, output digest_word, output last_word, input ready);
  modport sink (input valid, input digest_word, input last_word, output ready);
endinterface

/* rtl/sha_front.sv */
// ----------------------------------------------------------------------------
// SHA-256 front end
// Collects sixteen message words into a block and tags it with its flags.
// ----------------------------------------------------------------------------
module sha_front
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  sha_in_if.sink     msg,
  output logic       push_valid,
  input  logic       push_ready,
  output sha_block_t push_block
);

  block_words_t      words;
  logic [WIDX_W-1:0] word_index;
  logic              reload_pending;
  logic              last_pos;
  logic              accept;

  assign last_pos   = (word_index == WIDX_W'(BLOCK_WORDS - 1));
  assign msg.ready  = !last_pos || push_ready;
  assign accept     = msg.valid && msg.ready;
  assign push_valid = msg.valid && last_pos;

  always_comb begin
    push_block.words     = words;
    push_block.words[BLOCK_WORDS-1] = msg.msg_word;
    push_block.reload    = reload_pending;
    push_block.fin       = msg.final_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index     <= '0;
      reload_pending <= 1'b0;
    end else if (accept) begin
      word_index <= last_pos ? '0 : word_index + 1'b1;
      if (word_index == '0) begin
        reload_pending <= msg.new_message;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      words[word_index] <= msg.msg_word;
    end
  end

endmodule

/* rtl/sha_queue.sv */
// ----------------------------------------------------------------------------
// SHA-256 block queue
// Short queue of complete blocks between the front end and the round engine.
// ----------------------------------------------------------------------------
module sha_queue
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  sha_block_t push_block,
  output logic       pop_valid,
  input  logic       pop_ready,
  output sha_block_t pop_block
);

  sha_block_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_block  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_block;
    end
  end

endmodule

/* rtl/sha_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 round engine
// Runs the 64 rounds on a queued block, updates the chaining hash and
// streams out the digest after a final block.
// ----------------------------------------------------------------------------
module sha_core
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  sha_block_t pop_block,
  sha_out_if.source  digest
);

  sha_state_t        state;
  sha_state_t        state_next;
  hash_t             chain;
  hash_t             vars;
  hash_t             vars_next;
  block_words_t      sched;
  word_t             sched_new;
  word_t             t1;
  word_t             t2;
  logic [RND_W-1:0]  rnd;
  logic [HIDX_W-1:0] emit_cnt;
  logic              fin;
  logic              out_valid;
  word_t             out_word;
  logic              out_last;
  logic              emit_load;
  logic              take;

  assign digest.valid       = out_valid;
  assign digest.digest_word = out_word;
  assign digest.last_word   = out_last;

  always_comb begin
    t1 = vars[7] + big_s1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
       + round_k(rnd) + sched[0];
    t2 = big_s0(vars[0]) + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
    vars_next = {vars[6], vars[5], vars[4], vars[3] + t1, vars[2], vars[1], vars[0], t1 + t2};
    sched_new = small_s1(sched[14]) + sched[9] + small_s0(sched[1]) + sched[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    emit_load  = 1'b0;
    take       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          take       = 1'b1;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == RND_W'(ROUNDS - 1)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        state_next = fin ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid || digest.ready) begin
          emit_load = 1'b1;
          if (emit_cnt == HIDX_W'(HASH_WORDS - 1)) begin
            state_next = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain     <= INIT_HASH;
      out_valid <= 1'b0;
    end else begin
      if (take && pop_block.reload) begin
        chain <= INIT_HASH;
      end else if (state == ST_ADD) begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (digest.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sched <= pop_block.words;
      vars  <= pop_block.reload ? INIT_HASH : chain;
      fin   <= pop_block.fin;
      rnd   <= '0;
    end else if (state == ST_ROUND) begin
      sched <= {sched_new, sched[BLOCK_WORDS-1:1]};
      vars  <= vars_next;
      rnd   <= rnd + 1'b1;
    end
    if (state == ST_ADD) begin
      emit_cnt <= '0;
    end else if (emit_load) begin
      emit_cnt <= emit_cnt + 1'b1;
    end
    if (emit_load) begin
      out_word <= chain[emit_cnt];
      out_last <= (emit_cnt == HIDX_W'(HASH_WORDS - 1));
    end
  end

endmodule

/* rtl/sha256_block_hash.sv */
// ----------------------------------------------------------------------------
// SHA-256 block hash
// Top level: front end, block queue and round engine.
// ----------------------------------------------------------------------------
// Words of a padded message enter one per accepted request, sixteen to a
// block. new_message on a block's first word restarts from the standard
// initial hash; final_block on its sixteenth word makes the block emit the
// eight digest words afterwards, most significant first, the eighth marked
// by last_word. The round engine takes in each block in a load state, runs
// the 64 rounds at one per cycle and then adds the result into the
// chaining hash; after a final block it also hands out the digest words.
// A two-block queue sits between the word collector and the round engine,
// so the next blocks are taken in while one is compressed and while digest
// words wait to be taken.
module sha256_block_hash
  import sha_pkg::*;
(
  input logic       clk,
  input logic       rst,
  sha_in_if.sink    msg,
  sha_out_if.source digest
);

  logic       push_valid;
  logic       push_ready;
  sha_block_t push_block;
  logic       pop_valid;
  logic       pop_ready;
  sha_block_t pop_block;

  sha_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_block (push_block)
  );

  sha_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_block (push_block),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_block  (pop_block)
  );

  sha_core u_core (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_block (pop_block),
    .digest    (digest)
  );

endmodule

/* rtl/sha_checker.sv */
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the digest channel of the block hash and checks its framing.
// ----------------------------------------------------------------------------
module sha_checker
  import sha_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic        last_word
);

  logic [HIDX_W-1:0] out_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
    end else if (out_valid && out_ready) begin
      out_cnt <= out_cnt + 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Digest request shown right after reset.");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Digest request withdrawn while stalled.");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(digest_word) && $stable(last_word))
    else $error("Digest payload changed while stalled.");

  a_last_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (out_cnt == HIDX_W'(HASH_WORDS - 1))))
    else $error("Last digest word marker out of place.");

endmodule

bind sha256_block_hash sha_checker u_sha_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (digest.valid),
  .out_ready   (digest.ready),
  .digest_word (digest.digest_word),
  .last_word   (digest.last_word)
);
